// ----- design/assert_macros.svh -----
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked property, disabled while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold at a clock edge
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

// ----- design/pis_pkg.sv -----
// package with widths, constants, types and helpers of the poisson inversion sampler
`default_nettype none

package pis_pkg;

    // table geometry
    localparam int TABLE_SIZE = 46;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

    // field widths
    localparam int VAL_W      = 33;
    localparam int MEAN_W     = 32;
    localparam int U_W        = 32;
    localparam int COUNT_W    = 6;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_IDX_W  = 1;

    // term unit arithmetic: 33x32 product, quotient after dropping 28 fraction bits
    localparam int PROD_W     = VAL_W + MEAN_W;
    localparam int FRAC_SHIFT = 28;
    localparam int QUO_W      = PROD_W - FRAC_SHIFT;
    localparam int DIVC_W     = $clog2(QUO_W + 1);
    localparam int REM_W      = CNT_W + 1;

    // constants
    localparam logic [U_W-1:0]   U_THRESHOLD = 32'd1967095021;
    localparam logic [VAL_W-1:0] Q32_ONE     = 33'h1_0000_0000;
    localparam logic [VAL_W-1:0] VAL_MAX     = {VAL_W{1'b1}};
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(TABLE_SIZE - 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP  = 1'b1;

    // request to the pmf term unit
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] k;
    } term_req_t;

    // integer part of the mean, clamped to the last table index
    function automatic logic [IDX_W-1:0] floor_mean(input logic [MEAN_W-1:0] mean);
        logic [3:0] f;
        f = mean[MEAN_W-1:MEAN_W-4];
        if (32'(f) > TABLE_SIZE - 1)
            return LAST_IDX;
        else
            return IDX_W'(f);
    endfunction

    // table index to the count field
    function automatic logic [COUNT_W-1:0] to_count(input logic [IDX_W-1:0] idx);
        logic [IDX_W+COUNT_W-1:0] w;
        w = {{COUNT_W{1'b0}}, idx};
        return w[COUNT_W-1:0];
    endfunction

    // saturating add of two table values
    function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VAL_W] ? VAL_MAX : s[VAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/pis_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module pis_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 46
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/pis_term_unit.sv -----
// pmf term unit: round_half_up(p * lambda / (k * 2^28)) saturated to 33 bits
`default_nettype none

module pis_term_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pis_pkg::term_req_t            req,
    input  wire logic [pis_pkg::VAL_W-1:0]     pmf_in,
    input  wire logic [pis_pkg::MEAN_W-1:0]    mean,
    output logic                               done,
    output logic      [pis_pkg::VAL_W-1:0]     term
);

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_MLO  = 3'd1;
    localparam logic [2:0] T_MHI  = 3'd2;
    localparam logic [2:0] T_DIV  = 3'd3;
    localparam logic [2:0] T_FIN  = 3'd4;

    logic [2:0]                   state_reg, state_next;
    logic [pis_pkg::VAL_W-1:0]    p_reg, p_next;
    logic [pis_pkg::MEAN_W-1:0]   lam_reg, lam_next;
    logic [pis_pkg::CNT_W-1:0]    k_reg, k_next;
    logic [pis_pkg::PROD_W-1:0]   acc_reg, acc_next;
    logic [pis_pkg::QUO_W-1:0]    quo_reg, quo_next;
    logic [pis_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [pis_pkg::DIVC_W-1:0]   cnt_reg, cnt_next;

    logic [pis_pkg::VAL_W+15:0]   prod_lo;
    logic [pis_pkg::VAL_W+15:0]   prod_hi;
    logic [pis_pkg::PROD_W-1:0]   bias;
    logic [pis_pkg::PROD_W-1:0]   sum_lo;
    logic [pis_pkg::PROD_W-1:0]   sum_hi;
    logic [pis_pkg::REM_W-1:0]    shifted;
    logic [pis_pkg::REM_W-1:0]    k_ext;

    // partial products of p by the two halves of lambda
    assign prod_lo = p_reg * lam_reg[15:0];
    assign prod_hi = p_reg * lam_reg[31:16];

    // half of the divisor k*2^28 for rounding
    assign bias    = pis_pkg::PROD_W'(k_reg) << (pis_pkg::FRAC_SHIFT - 1);
    assign sum_lo  = pis_pkg::PROD_W'(prod_lo) + bias;
    assign sum_hi  = acc_reg + (pis_pkg::PROD_W'(prod_hi) << 16);

    // one restoring division step by k
    assign shifted = {rem_reg[pis_pkg::REM_W-2:0], quo_reg[pis_pkg::QUO_W-1]};
    assign k_ext   = {1'b0, k_reg};

    // saturated quotient
    assign done = (state_reg == T_FIN);
    assign term = (|quo_reg[pis_pkg::QUO_W-1:pis_pkg::VAL_W]) ? pis_pkg::VAL_MAX
                                                             : quo_reg[pis_pkg::VAL_W-1:0];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        lam_next   = lam_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (req.start)
                begin
                    p_next     = pmf_in;
                    lam_next   = mean;
                    k_next     = req.k;
                    state_next = T_MLO;
                end
            end
            T_MLO:
            begin
                acc_next   = sum_lo;
                state_next = T_MHI;
            end
            T_MHI:
            begin
                quo_next   = sum_hi[pis_pkg::PROD_W-1:pis_pkg::FRAC_SHIFT];
                rem_next   = '0;
                cnt_next   = pis_pkg::DIVC_W'(pis_pkg::QUO_W);
                state_next = T_DIV;
            end
            T_DIV:
            begin
                if (shifted >= k_ext)
                begin
                    rem_next = shifted - k_ext;
                    quo_next = {quo_reg[pis_pkg::QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    quo_next = {quo_reg[pis_pkg::QUO_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == pis_pkg::DIVC_W'(1))
                begin
                    state_next = T_FIN;
                end
            end
            T_FIN:
            begin
                state_next = T_IDLE;
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        lam_reg <= lam_next;
        k_reg   <= k_next;
        acc_reg <= acc_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

endmodule

`default_nettype wire

// ----- design/poisson_inversion_sampler_top.sv -----
// top level of the poisson inversion sampler: sequencer, table ram and term unit
//
// Maps one uniform sample u (Q0.32) to a Poisson count by searching a Q1.32
// cumulative table held in a 46-entry ram. One sample is in work at a time.
// The search reads one entry per cycle through the ram's registered port,
// walking the entries from 0, or from floor(lambda) when u > 0.458. Each
// entry after entry 0 that has to be added is built in the term unit: two
// partial products, 37 restoring division steps, start and finish. After
// reset or any register write the first sample also builds entries
// 0..floor(lambda); later entries are added only when a search runs past
// the table end. No clearing pass: only written entries are ever read.
// Registers may be written only while no sample is in work.
`default_nettype none
`include "assert_macros.svh"

module poisson_inversion_sampler_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [pis_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pis_pkg::VAL_W-1:0]         cfg_wdata,
    // sample request
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [pis_pkg::U_W-1:0]           s_tdata,   // [31:0] uniform_sample
    // result request
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [pis_pkg::M_TDATA_W-1:0]     m_tdata,   // [5:0] count, [7:6] zero
    output logic                                   m_tuser    // [0] table_exhausted
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_INIT   = 3'd1;
    localparam logic [2:0] ST_TSTART = 3'd2;
    localparam logic [2:0] ST_TWAIT  = 3'd3;
    localparam logic [2:0] ST_SRCH   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [pis_pkg::MEAN_W-1:0]     mean_reg, mean_next;
    logic [pis_pkg::VAL_W-1:0]      exp_reg, exp_next;
    logic [pis_pkg::CNT_W-1:0]      filled_reg, filled_next;
    logic [pis_pkg::VAL_W-1:0]      last_p_reg, last_p_next;
    logic [pis_pkg::VAL_W-1:0]      last_cdf_reg, last_cdf_next;
    logic [pis_pkg::U_W-1:0]        u_reg, u_next;
    logic [pis_pkg::CNT_W-1:0]      k_reg, k_next;
    logic                           pend_reg, pend_next;
    logic [pis_pkg::IDX_W-1:0]      pidx_reg, pidx_next;
    logic                           ext_reg, ext_next;
    logic [pis_pkg::IDX_W-1:0]      res_reg, res_next;
    logic                           exh_reg, exh_next;
    logic                           out_valid_reg, out_valid_next;
    logic [pis_pkg::COUNT_W-1:0]    out_count_reg, out_count_next;
    logic                           out_exh_reg, out_exh_next;

    logic                           mem_we;
    logic [pis_pkg::IDX_W-1:0]      mem_waddr;
    logic [pis_pkg::VAL_W-1:0]      mem_wdata;
    logic                           mem_re;
    logic [pis_pkg::IDX_W-1:0]      mem_raddr;
    logic [pis_pkg::VAL_W-1:0]      mem_rdata;

    pis_pkg::term_req_t             term_req;
    logic                           term_start;
    logic                           term_done;
    logic [pis_pkg::VAL_W-1:0]      term_val;

    logic [pis_pkg::IDX_W-1:0]      top_idx;
    logic [pis_pkg::CNT_W-1:0]      next_fill;
    logic [pis_pkg::VAL_W-1:0]      t_sum;
    logic [pis_pkg::VAL_W-1:0]      t_new;
    logic                           out_load;

    // cumulative table
    pis_ram #(
        .WIDTH (pis_pkg::VAL_W),
        .DEPTH (pis_pkg::TABLE_SIZE)
    ) u_cdf_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // pmf recurrence for the entry at index filled
    assign term_req.start = term_start;
    assign term_req.k     = filled_reg;

    pis_term_unit u_term (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (term_req),
        .pmf_in (last_p_reg),
        .mean   (mean_reg),
        .done   (term_done),
        .term   (term_val)
    );

    // new entry value, forced to one on a zero term while extending
    assign top_idx   = pis_pkg::floor_mean(mean_reg);
    assign next_fill = filled_reg + 1'b1;
    assign t_sum     = pis_pkg::sat_add(last_cdf_reg, term_val);
    assign t_new     = (ext_reg && (term_val == '0)) ? pis_pkg::Q32_ONE : t_sum;

    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        mean_next     = mean_reg;
        exp_next      = exp_reg;
        filled_next   = filled_reg;
        last_p_next   = last_p_reg;
        last_cdf_next = last_cdf_reg;
        u_next        = u_reg;
        k_next        = k_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        ext_next      = ext_reg;
        res_next      = res_reg;
        exh_next      = exh_reg;
        mem_we        = 1'b0;
        mem_waddr     = filled_reg[pis_pkg::IDX_W-1:0];
        mem_wdata     = t_new;
        mem_re        = 1'b0;
        mem_raddr     = k_reg[pis_pkg::IDX_W-1:0];
        term_start    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    u_next    = s_tdata;
                    k_next    = (s_tdata > pis_pkg::U_THRESHOLD)
                                ? pis_pkg::CNT_W'(top_idx) : '0;
                    pend_next = 1'b0;
                    state_next = (filled_reg == '0) ? ST_INIT : ST_SRCH;
                end
            end
            ST_INIT:
            begin
                // entry zero is exp(-lambda)
                mem_we        = 1'b1;
                mem_waddr     = '0;
                mem_wdata     = exp_reg;
                last_p_next   = exp_reg;
                last_cdf_next = exp_reg;
                filled_next   = pis_pkg::CNT_W'(1);
                ext_next      = 1'b0;
                state_next    = (top_idx != '0) ? ST_TSTART : ST_SRCH;
            end
            ST_TSTART:
            begin
                term_start = 1'b1;
                state_next = ST_TWAIT;
            end
            ST_TWAIT:
            begin
                if (term_done)
                begin
                    mem_we        = 1'b1;
                    last_p_next   = term_val;
                    last_cdf_next = t_new;
                    filled_next   = next_fill;
                    if (!ext_reg)
                    begin
                        // initial fill up to floor(lambda)
                        state_next = (next_fill <= pis_pkg::CNT_W'(top_idx))
                                     ? ST_TSTART : ST_SRCH;
                    end
                    else if ({1'b0, u_reg} <= t_new)
                    begin
                        res_next   = filled_reg[pis_pkg::IDX_W-1:0];
                        exh_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else if (next_fill < pis_pkg::CNT_W'(pis_pkg::TABLE_SIZE))
                    begin
                        state_next = ST_TSTART;
                    end
                    else
                    begin
                        res_next   = pis_pkg::LAST_IDX;
                        exh_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SRCH:
            begin
                // registered read: data compared in the cycle after the read
                if (pend_reg && ({1'b0, u_reg} <= mem_rdata))
                begin
                    res_next   = pidx_reg;
                    exh_next   = 1'b0;
                    pend_next  = 1'b0;
                    state_next = ST_DONE;
                end
                else if (k_reg < filled_reg)
                begin
                    mem_re    = 1'b1;
                    pidx_next = k_reg[pis_pkg::IDX_W-1:0];
                    pend_next = 1'b1;
                    k_next    = k_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (filled_reg < pis_pkg::CNT_W'(pis_pkg::TABLE_SIZE))
                    begin
                        ext_next   = 1'b1;
                        state_next = ST_TSTART;
                    end
                    else
                    begin
                        res_next   = pis_pkg::LAST_IDX;
                        exh_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // register write empties the table
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                pis_pkg::CFG_MEAN: mean_next = cfg_wdata[pis_pkg::MEAN_W-1:0];
                pis_pkg::CFG_EXP:  exp_next  = cfg_wdata;
            endcase
            filled_next = '0;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        out_exh_next   = out_exh_reg;
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
            out_count_next = pis_pkg::to_count(res_reg);
            out_exh_next   = exh_reg;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mean_reg      <= '0;
            exp_reg       <= pis_pkg::Q32_ONE;
            filled_reg    <= '0;
            last_p_reg    <= '0;
            last_cdf_reg  <= '0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            ext_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mean_reg      <= mean_next;
            exp_reg       <= exp_next;
            filled_reg    <= filled_next;
            last_p_reg    <= last_p_next;
            last_cdf_reg  <= last_cdf_next;
            k_reg         <= k_next;
            pend_reg      <= pend_next;
            ext_reg       <= ext_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        u_reg         <= u_next;
        pidx_reg      <= pidx_next;
        res_reg       <= res_next;
        exh_reg       <= exh_next;
        out_count_reg <= out_count_next;
        out_exh_reg   <= out_exh_next;
    end

    // ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(pis_pkg::M_TDATA_W - pis_pkg::COUNT_W){1'b0}}, out_count_reg};
    assign m_tuser  = out_exh_reg;

    // checks
    `ASSERT_CLK(a_accept_leaves_idle, (s_tvalid && s_tready) |=> (state_reg != ST_IDLE), "accepted sample left sequencer idle")
    `ASSERT_NEVER(a_term_done_in_wait, term_done && (state_reg != ST_TWAIT), "term unit finished while sequencer not waiting")
    `ASSERT_CLK(a_clamp_on_exhaust, (m_tvalid && m_tuser) |-> (m_tdata[pis_pkg::COUNT_W-1:0] == pis_pkg::to_count(pis_pkg::LAST_IDX)), "exhausted result not clamped to last index")
    `ASSERT_CLK(a_done_delivers, (state_reg == ST_DONE && !(m_tvalid && !m_tready)) |=> (m_tvalid && state_reg == ST_IDLE), "finished sample not moved to output register")

endmodule

`default_nettype wire

// ----- tb/sv/poisson_inversion_sampler_top_test.sv -----
// testbench of the poisson inversion sampler: table predictor, stream driver and result checker
`timescale 1ns / 100ps

module poisson_inversion_sampler_top_test;

    localparam int RANDOM_ITEMS = 1530;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int IDLE_PCT     = 26;

    // one expected result, with the sample that caused it
    typedef struct packed {
        logic [pis_pkg::U_W-1:0]     u;
        logic [pis_pkg::COUNT_W-1:0] count;
        logic                        exhausted;
    } count_expect_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_wr_en = 1'b0;
    logic [pis_pkg::CFG_IDX_W-1:0]     cfg_index = pis_pkg::CFG_MEAN;
    logic [pis_pkg::VAL_W-1:0]         cfg_wdata = '0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [pis_pkg::U_W-1:0]           s_tdata = '0;   // [31:0] uniform_sample
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [pis_pkg::M_TDATA_W-1:0]     m_tdata;        // [5:0] count, [7:6] zero
    logic                              m_tuser;        // [0] table_exhausted

    logic [pis_pkg::U_W-1:0]           pending_samples[$];
    count_expect_t                     expected_counts[$];
    int                                mismatches = 0;
    int                                cycles = 0;
    bit                                steady = 1'b0;

    // predictor state: registers and the cumulative table
    logic [pis_pkg::MEAN_W-1:0]        mean_reg = '0;
    logic [pis_pkg::VAL_W-1:0]         exp_reg = pis_pkg::Q32_ONE;
    logic [pis_pkg::VAL_W-1:0]         cdf_model[pis_pkg::TABLE_SIZE];
    int                                cdf_filled = 0;
    logic [pis_pkg::VAL_W-1:0]         last_pmf = '0;

    poisson_inversion_sampler_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // next pmf term: p*lambda/(k*2^28) rounded half up, saturated to 33 bits
    function automatic logic [pis_pkg::VAL_W-1:0] pmf_next(
        input logic [pis_pkg::VAL_W-1:0]  p,
        input logic [pis_pkg::MEAN_W-1:0] lam,
        input int                         k);
        logic [71:0] den;
        logic [71:0] num;
        logic [71:0] quo;
        den = 72'(k) << pis_pkg::FRAC_SHIFT;
        num = 72'(p) * 72'(lam) + (den >> 1);
        quo = num / den;
        return (quo > 72'(pis_pkg::VAL_MAX)) ? pis_pkg::VAL_MAX : quo[pis_pkg::VAL_W-1:0];
    endfunction

    function automatic int mean_floor();
        int f;
        f = int'(mean_reg[pis_pkg::MEAN_W-1:pis_pkg::MEAN_W-4]);
        return (f > pis_pkg::TABLE_SIZE - 1) ? pis_pkg::TABLE_SIZE - 1 : f;
    endfunction

    // add one table entry; lazy entries with a zero term become 1.0
    function automatic void cdf_append(input bit force_one);
        int                          k;
        logic [pis_pkg::VAL_W-1:0]   p;
        logic [pis_pkg::VAL_W:0]     s;
        logic [pis_pkg::VAL_W-1:0]   t;
        k = cdf_filled;
        p = pmf_next(last_pmf, mean_reg, k);
        s = {1'b0, cdf_model[k-1]} + {1'b0, p};
        t = s[pis_pkg::VAL_W] ? pis_pkg::VAL_MAX : s[pis_pkg::VAL_W-1:0];
        if (force_one && p == '0)
            t = pis_pkg::Q32_ONE;
        last_pmf = p;
        cdf_model[k] = t;
        cdf_filled = k + 1;
    endfunction

    function automatic void cdf_rebuild();
        cdf_model[0] = exp_reg;
        last_pmf = exp_reg;
        cdf_filled = 1;
        while (cdf_filled <= mean_floor())
            cdf_append(1'b0);
    endfunction

    function automatic void apply_reg(input logic [pis_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [pis_pkg::VAL_W-1:0] val);
        if (idx == pis_pkg::CFG_MEAN)
            mean_reg = val[pis_pkg::MEAN_W-1:0];
        else
            exp_reg = val;
        cdf_filled = 0;
    endfunction

    // count for one sample, extending the table as the search needs
    function automatic count_expect_t predict_count(input logic [pis_pkg::U_W-1:0] u);
        count_expect_t  r;
        int             k;
        bit             hit;
        r.u = u;
        r.count = pis_pkg::COUNT_W'(pis_pkg::TABLE_SIZE - 1);
        hit = 1'b0;
        if (cdf_filled == 0)
            cdf_rebuild();
        k = (u > pis_pkg::U_THRESHOLD) ? mean_floor() : 0;
        while (!hit && k < cdf_filled)
        begin
            if ({1'b0, u} <= cdf_model[k])
            begin
                r.count = pis_pkg::COUNT_W'(k);
                hit = 1'b1;
            end
            k++;
        end
        while (!hit && cdf_filled < pis_pkg::TABLE_SIZE)
        begin
            cdf_append(1'b1);
            if ({1'b0, u} <= cdf_model[cdf_filled-1])
            begin
                r.count = pis_pkg::COUNT_W'(cdf_filled - 1);
                hit = 1'b1;
            end
        end
        r.exhausted = !hit;
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    // sample driver: loads the next request when the slot frees, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_counts.push_back(predict_count(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (pending_samples.size() != 0 &&
                    (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_samples.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random backpressure
    always @(posedge clk or negedge rst_n)
    begin
        count_expect_t e;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_counts.size() == 0)
                begin
                    flag_mismatch($sformatf("result count %0d with nothing expected",
                                            m_tdata[pis_pkg::COUNT_W-1:0]));
                end
                else
                begin
                    e = expected_counts.pop_front();
                    if (m_tdata[pis_pkg::COUNT_W-1:0] !== e.count)
                        flag_mismatch($sformatf("u %h count %0d, expected %0d",
                                                e.u, m_tdata[pis_pkg::COUNT_W-1:0],
                                                e.count));
                    if (m_tdata[pis_pkg::M_TDATA_W-1:pis_pkg::COUNT_W] !== '0)
                        flag_mismatch($sformatf("u %h padding bits %b not zero", e.u,
                                                m_tdata[pis_pkg::M_TDATA_W-1:pis_pkg::COUNT_W]));
                    if (m_tuser !== e.exhausted)
                        flag_mismatch($sformatf("u %h table_exhausted %b, expected %b",
                                                e.u, m_tuser, e.exhausted));
                end
            end
            m_tready <= steady || $urandom_range(99) >= IDLE_PCT;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("poisson_inversion_sampler_top_test failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [pis_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pis_pkg::VAL_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        apply_reg(idx, val);
    endtask

    task automatic write_both(input logic [pis_pkg::MEAN_W-1:0] mean,
                              input logic [pis_pkg::VAL_W-1:0] expv);
        if ($urandom_range(1) == 0)
        begin
            write_reg(pis_pkg::CFG_MEAN, pis_pkg::VAL_W'(mean));
            write_reg(pis_pkg::CFG_EXP, expv);
        end
        else
        begin
            write_reg(pis_pkg::CFG_EXP, expv);
            write_reg(pis_pkg::CFG_MEAN, pis_pkg::VAL_W'(mean));
        end
    endtask

    // wait until every request went out and every result came back
    task automatic drain();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || s_tvalid || expected_counts.size() != 0);
        repeat ($urandom_range(1, 4)) @(posedge clk);
    endtask

    function automatic logic [pis_pkg::U_W-1:0] random_sample();
        case ($urandom_range(15))
            0:       return pis_pkg::U_THRESHOLD - 32'd4 + pis_pkg::U_W'($urandom_range(8));
            1:       return pis_pkg::U_W'($urandom_range(1000));
            2:       return 32'hFFFF_FFFF - pis_pkg::U_W'($urandom_range(1000));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [pis_pkg::VAL_W-1:0] random_exp();
        return {1'($urandom_range(1)), 32'($urandom())};
    endfunction

    // means with a matching exp(-lambda), both in register format
    logic [pis_pkg::MEAN_W-1:0] fit_mean[8] = '{32'h0199_999A, 32'h0800_0000, 32'h1000_0000,
                                                32'h2800_0000, 32'h4000_0000, 32'h5C00_0000,
                                                32'h7000_0000, 32'hA000_0000};
    logic [pis_pkg::VAL_W-1:0]  fit_exp[8]  = '{33'd3886245323, 33'd2605029349, 33'd1580030169,
                                                33'd352552391, 33'd78664902, 33'd13670022,
                                                33'd3916502, 33'd194991};

    initial
    begin
        int random_sent;
        int n;
        int pick;
        random_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: t[0] is 1.0, every sample gives zero
        pending_samples = '{32'h0000_0000, 32'hFFFF_FFFF, pis_pkg::U_THRESHOLD + 32'd1};
        drain();

        // mean 10 with its exp(-lambda): both search starts, field extremes
        write_both(32'hA000_0000, 33'd194991);
        pending_samples = '{32'h0000_0000, pis_pkg::U_THRESHOLD,
                            pis_pkg::U_THRESHOLD + 32'd1,
                            32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_1000};
        drain();

        // zero first entry: initial fill stays zero, first lazy entry forced to 1.0
        write_reg(pis_pkg::CFG_EXP, '0);
        pending_samples = '{32'h0000_0000, pis_pkg::U_THRESHOLD + 32'd1, 32'hFFFF_FFFF};
        drain();

        // mean above range with a tiny first entry: floor 15 and table end
        write_both(32'hFFFF_FFFF, 33'd100);
        pending_samples = '{32'hFFFF_FFFF, 32'h0000_0000, pis_pkg::U_THRESHOLD + 32'd1,
                            32'h4000_0000};
        drain();

        // largest first entry: saturating terms and sums
        write_both(32'hA000_0000, pis_pkg::VAL_MAX);
        pending_samples = '{32'h0000_0000, 32'hFFFF_FFFF};
        drain();

        // zero mean and zero first entry
        write_both(32'h0000_0000, '0);
        pending_samples = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF};
        drain();

        // random phases, each under a new setting
        while (random_sent < RANDOM_ITEMS)
        begin
            steady = (random_sent >= 500 && random_sent < 850);
            pick = $urandom_range(7);
            case ($urandom_range(9))
                0, 1, 2, 3, 4: write_both(fit_mean[pick], fit_exp[pick]);
                5:  write_both(pis_pkg::MEAN_W'($urandom_range(32'hA000_0000)),
                               pis_pkg::VAL_W'($urandom_range(32'hFFFF_FFFF)) +
                               pis_pkg::VAL_W'($urandom_range(1)));
                6:  write_reg(pis_pkg::CFG_MEAN, pis_pkg::VAL_W'($urandom()));
                7:  write_reg(pis_pkg::CFG_EXP, random_exp());
                8:  write_both(32'hF000_0000 | pis_pkg::MEAN_W'($urandom_range(32'h0FFF_FFFF)),
                               pis_pkg::VAL_W'($urandom_range(30, 400)));
                default:
                begin
                    case ($urandom_range(2))
                        0:       write_both(pis_pkg::MEAN_W'($urandom_range(32'hA000_0000)),
                                            '0);
                        1:       write_both(pis_pkg::MEAN_W'($urandom_range(32'hA000_0000)),
                                            pis_pkg::Q32_ONE);
                        default: write_both(pis_pkg::MEAN_W'($urandom_range(32'hA000_0000)),
                                            pis_pkg::VAL_MAX);
                    endcase
                end
            endcase
            n = $urandom_range(20, 90);
            repeat (n) pending_samples.push_back(random_sample());
            random_sent += n;
            drain();
        end
        steady = 1'b0;

        repeat (100) @(posedge clk);
        if (expected_counts.size() != 0)
            flag_mismatch($sformatf("%0d results never came", expected_counts.size()));
        if (mismatches == 0)
            $display("poisson_inversion_sampler_top_test passed");
        else
            $display("poisson_inversion_sampler_top_test failed");
        $finish;
    end

endmodule
